// File: rtl/core/cptab_pkg.sv
`default_nettype none
// ============================================================================
// cptab_pkg
// Shared types and constants of the capability table: entry layout, memory
// request, configuration bundle, operation and status codes.
// ============================================================================
package cptab_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int FUNC_W    = 2;
    localparam int KIND_W    = 4;
    localparam int RES_W     = 64;
    localparam int HANDLE_W  = 8;
    localparam int RIGHTS_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_GRANT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REVOKE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd2;

    // rights mask
    localparam int                    RIGHT_SEND_BIT = 0;
    localparam logic [RIGHTS_W-1:0]   RIGHTS_ALL     = 2'b11;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_NAMESPACE_KIND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_KIND  = 8'd1;
    localparam logic [KIND_W-1:0]    NAMESPACE_KIND_RST = 4'd1;
    localparam logic [KIND_W-1:0]    ENDPOINT_KIND_RST  = 4'd2;

    // one table entry
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [RES_W-1:0]    resource;
        logic [HANDLE_W-1:0] handle;
        logic [RIGHTS_W-1:0] rights;
    } entry_t;

    // request to the entry memory: one write and one read port
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    // configuration registers
    typedef struct packed {
        logic [KIND_W-1:0] namespace_kind;
        logic [KIND_W-1:0] endpoint_kind;
    } cfg_t;

endpackage : cptab_pkg
`default_nettype wire

// File: rtl/core/cptab_mem.sv
`default_nettype none
// ============================================================================
// cptab_mem
// Entry storage: one write port, one read port, read data registered.
// ============================================================================
module cptab_mem
    import cptab_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem_array [MAX_ENTRIES];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.waddr] <= req.wdata;
        end
    end

    // read port, read data registered
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem_array[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : cptab_mem
`default_nettype wire

// File: rtl/core/cptab_cfg.sv
`default_nettype none
// ============================================================================
// cptab_cfg
// Configuration registers: namespace and endpoint kind codes.
// ============================================================================
module cptab_cfg
    import cptab_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KIND_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // always able to take a write
    assign cfg_ready = 1'b1;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NAMESPACE_KIND: cfg_next.namespace_kind = cfg_data;
                REG_ENDPOINT_KIND:  cfg_next.endpoint_kind  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.namespace_kind <= NAMESPACE_KIND_RST;
            cfg_reg.endpoint_kind  <= ENDPOINT_KIND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : cptab_cfg
`default_nettype wire

// File: rtl/core/capability_table_core.sv
`default_nettype none
// Grant, func code three, revoke of handle zero: no walk, the result goes from
// execute to response state to the output register. Revoke, check: the walk
// streams live entries from the one read port, an entry per cycle; a check ends
// at its first hit. A new item is taken only when idle; one waiting result does
// not stall the input. Reset clears count and endpoint, loads config reset
// values; memory is not cleared, slots at or above the count are never read.
// ============================================================================
// capability_table_core
// Per-task capability table: grant appends, revoke removes and compacts,
// check looks for a namespace entry with send right.
// ============================================================================
module capability_table_core
    import cptab_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input items
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [FUNC_W-1:0]    func,
    input  logic [KIND_W-1:0]    cap_kind,
    input  logic [RES_W-1:0]     resource_word,
    input  logic [HANDLE_W-1:0]  handle_in,
    // result items
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [HANDLE_W-1:0]  handle_out,
    output logic                 send_allowed,
    output logic [HANDLE_W-1:0]  endpoint_handle,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KIND_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    cfg_t     cfg;
    mem_req_t mem_req;
    entry_t   rd_data;

    // latched item
    logic [FUNC_W-1:0]   func_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [RES_W-1:0]    res_reg;
    logic [HANDLE_W-1:0] hin_reg;

    // table state
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [HANDLE_W-1:0] ep_reg, ep_next;

    // walk pointers
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                found_reg, found_next;

    // pending result
    logic [STATUS_W-1:0] rst_status_reg, rst_status_next;
    logic [HANDLE_W-1:0] rst_handle_reg, rst_handle_next;
    logic                rst_send_reg, rst_send_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [HANDLE_W-1:0] handle_out_reg;
    logic                send_reg;
    logic [HANDLE_W-1:0] ep_out_reg;

    logic                out_free;
    logic                out_load;
    logic                issue;
    logic [HANDLE_W-1:0] grant_sum;
    logic [HANDLE_W-1:0] grant_handle;
    logic                grant_ok;

    cptab_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cptab_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_RESP) && out_free;

    // handle for a grant into slot count, zero wraps to one
    assign grant_sum    = HANDLE_W'(count_reg) + HANDLE_W'(1);
    assign grant_handle = (grant_sum == '0) ? HANDLE_W'(1) : grant_sum;
    assign grant_ok     = (kind_reg != '0) && (count_reg < CNT_W'(MAX_ENTRIES));

    // next read of the walk, stops at the live count
    assign issue = (state_reg == S_WALK) && (rd_ptr_reg < count_reg);

    // control and memory access
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ep_next         = ep_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        rst_status_next = rst_status_reg;
        rst_handle_next = rst_handle_reg;
        rst_send_next   = rst_send_reg;

        mem_req.we             = 1'b0;
        mem_req.waddr          = count_reg[IDX_W-1:0];
        mem_req.wdata.kind     = kind_reg;
        mem_req.wdata.resource = res_reg;
        mem_req.wdata.handle   = grant_handle;
        mem_req.wdata.rights   = RIGHTS_ALL;
        mem_req.re             = issue;
        mem_req.raddr          = rd_ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                rst_status_next = ST_INVALID;
                rst_handle_next = '0;
                rst_send_next   = 1'b0;
                rd_ptr_next     = '0;
                found_next      = 1'b0;
                state_next      = S_RESP;
                case (func_reg)
                    FUNC_GRANT:
                    begin
                        if (grant_ok)
                        begin
                            mem_req.we      = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            rst_status_next = ST_OK;
                            rst_handle_next = grant_handle;
                            if (kind_reg == cfg.endpoint_kind)
                            begin
                                ep_next = grant_handle;
                            end
                        end
                        else
                        begin
                            rst_status_next = ST_LIMIT;
                        end
                    end
                    FUNC_REVOKE:
                    begin
                        if (hin_reg != '0)
                        begin
                            state_next = S_WALK;
                        end
                    end
                    FUNC_CHECK:
                    begin
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        rst_status_next = ST_INVALID;
                    end
                endcase
            end

            S_WALK:
            begin
                // stream reads, one entry per cycle
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_ptr_reg[IDX_W-1:0];
                end
                // look at the entry read last cycle
                if (rd_vld_reg)
                begin
                    if (found_reg)
                    begin
                        // compaction: entry moves down one slot
                        mem_req.we    = 1'b1;
                        mem_req.waddr = rd_idx_reg - IDX_W'(1);
                        mem_req.wdata = rd_data;
                    end
                    else if (func_reg == FUNC_REVOKE)
                    begin
                        if (rd_data.handle == hin_reg)
                        begin
                            found_next = 1'b1;
                        end
                    end
                    else if ((rd_data.handle == hin_reg) &&
                             (rd_data.kind == cfg.namespace_kind) &&
                             rd_data.rights[RIGHT_SEND_BIT])
                    begin
                        rst_status_next = ST_OK;
                        rst_send_next   = 1'b1;
                        state_next      = S_RESP;
                    end
                end
                // walk finished without an early hit
                if (!rd_vld_reg && !issue)
                begin
                    state_next = S_RESP;
                    if (func_reg == FUNC_CHECK)
                    begin
                        rst_status_next = ST_OK;
                    end
                    else if (found_reg)
                    begin
                        rst_status_next = ST_OK;
                        count_next      = count_reg - CNT_W'(1);
                        if (ep_reg == hin_reg)
                        begin
                            ep_next = '0;
                        end
                    end
                    else
                    begin
                        rst_status_next = ST_INVALID;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ep_reg        <= '0;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ep_reg        <= ep_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg <= func;
            kind_reg <= cap_kind;
            res_reg  <= resource_word;
            hin_reg  <= handle_in;
        end
        rd_idx_reg     <= rd_idx_next;
        rst_status_reg <= rst_status_next;
        rst_handle_reg <= rst_handle_next;
        rst_send_reg   <= rst_send_next;
        if (out_load)
        begin
            status_reg     <= rst_status_reg;
            handle_out_reg <= rst_handle_reg;
            send_reg       <= rst_send_reg;
            ep_out_reg     <= ep_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign handle_out      = handle_out_reg;
    assign send_allowed    = send_reg;
    assign endpoint_handle = ep_out_reg;

    // live count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // compaction write never lands on the slot being read
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr)))
        else $error("memory read and write hit the same slot");

    // only a good grant returns a handle
    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (handle_out != '0)) |-> (status == ST_OK))
        else $error("handle returned with failing status");

    // the walk pointer of a revoke or check never passes the live count
    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (rd_ptr_reg <= count_reg))
        else $error("walk pointer past live count");

endmodule : capability_table_core
`default_nettype wire

// File: dv/capability_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capability_table_core_test
// Self-checking bench for the capability table. A short table of directed
// items covers grant, revoke and check at the edges of the table. Random
// operations follow under several kind-code settings. Each result is compared
// with the directed row's expected item or a behavioral model in the bench.
// ----------------------------------------------------------------------------
module capability_table_core_test;
    import cptab_pkg::*;

    // bench constants
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_UNUSED  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP     = 8'hFF;
    localparam int                   RESET_CYCLES    = 11;
    localparam int                   CYCLE_LIMIT     = 600000;
    localparam int                   HOLD_CYCLES     = 300;
    localparam int                   IDLE_PCT        = 11;
    localparam int                   N_DIRECTED      = 24;
    localparam int                   N_PHASES        = 5;
    localparam int                   ITEMS_PER_PHASE = 350;
    localparam int                   DRAIN_CYCLES    = 30;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic                send;
        logic [HANDLE_W-1:0] endpoint;
    } table_result_t;

    // one row of the directed table
    typedef struct {
        logic [FUNC_W-1:0]   op;
        logic [KIND_W-1:0]   kind;
        logic [RES_W-1:0]    res;
        logic [HANDLE_W-1:0] handle;
        int                  reps;
        bit                  typed;
        table_result_t       want;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func;
    logic [KIND_W-1:0]    cap_kind;
    logic [RES_W-1:0]     resource_word;
    logic [HANDLE_W-1:0]  handle_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic [HANDLE_W-1:0]  handle_out;
    logic                 send_allowed;
    logic [HANDLE_W-1:0]  endpoint_handle;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KIND_W-1:0]    cfg_data;

    // model of the table
    entry_t               cap_tbl [MAX_ENTRIES];
    int                   live_count;
    logic [HANDLE_W-1:0]  cur_endpoint;
    logic [KIND_W-1:0]    ns_kind;
    logic [KIND_W-1:0]    ep_kind;

    table_result_t        pending_results [$];
    directed_row_t        directed_rows [N_DIRECTED];
    int                   fail_count = 0;
    int                   cycle_count = 0;
    bit                   idle_on = 1'b1;
    bit                   hold_request = 1'b0;

    capability_table_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .cap_kind        (cap_kind),
        .resource_word   (resource_word),
        .handle_in       (handle_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .handle_out      (handle_out),
        .send_allowed    (send_allowed),
        .endpoint_handle (endpoint_handle),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // apply one operation to the table model and return its result item
    function automatic table_result_t predict_table_op(input logic [FUNC_W-1:0] op,
                                                       input logic [KIND_W-1:0] kind,
                                                       input logic [RES_W-1:0] res,
                                                       input logic [HANDLE_W-1:0] h);
        table_result_t       r;
        int                  hit;
        logic [HANDLE_W-1:0] nh;
        r = '{ST_INVALID, 8'd0, 1'b0, 8'd0};
        hit = -1;
        case (op)
            FUNC_GRANT:
            begin
                if (kind == '0 || live_count >= MAX_ENTRIES)
                    r.status = ST_LIMIT;
                else
                begin
                    nh = HANDLE_W'(live_count + 1);
                    if (nh == '0)
                        nh = 8'd1;
                    cap_tbl[live_count] = '{kind, res, nh, RIGHTS_ALL};
                    if (kind == ep_kind)
                        cur_endpoint = nh;
                    live_count++;
                    r.status = ST_OK;
                    r.handle = nh;
                end
            end
            FUNC_REVOKE:
            begin
                if (h != '0)
                begin
                    for (int i = 0; i < live_count; i++)
                        if (hit < 0 && cap_tbl[i].handle == h)
                            hit = i;
                    // remove the first match and close the gap
                    if (hit >= 0)
                    begin
                        for (int j = hit; j < live_count - 1; j++)
                            cap_tbl[j] = cap_tbl[j + 1];
                        cap_tbl[live_count - 1] = '0;
                        live_count--;
                        if (cur_endpoint == h)
                            cur_endpoint = '0;
                        r.status = ST_OK;
                    end
                end
            end
            FUNC_CHECK:
            begin
                r.status = ST_OK;
                for (int i = 0; i < live_count; i++)
                    if (cap_tbl[i].handle == h && cap_tbl[i].kind == ns_kind &&
                        cap_tbl[i].rights[RIGHT_SEND_BIT])
                        r.send = 1'b1;
            end
            default: ;
        endcase
        r.endpoint = cur_endpoint;
        return r;
    endfunction

    // offer one item, wait for it to be taken, then queue its expected result
    task automatic send_item(input logic [FUNC_W-1:0] op, input logic [KIND_W-1:0] kind,
                             input logic [RES_W-1:0] res, input logic [HANDLE_W-1:0] h,
                             input bit typed, input table_result_t want);
        table_result_t predicted;
        if (idle_on)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        func          = op;
        cap_kind      = kind;
        resource_word = res;
        handle_in     = h;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_table_op(op, kind, res, h);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KIND_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_NAMESPACE_KIND)
            ns_kind = data;
        else if (idx == REG_ENDPOINT_KIND)
            ep_kind = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random operation biased toward live handles and the configured kinds
    task automatic pick_random_item(output logic [FUNC_W-1:0] op,
                                    output logic [KIND_W-1:0] kind,
                                    output logic [RES_W-1:0] res,
                                    output logic [HANDLE_W-1:0] h);
        int roll;
        int grant_pct;
        grant_pct = (live_count >= MAX_ENTRIES - 2) ? 25 : 45;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            op = FUNC_UNUSED;
        else if (roll < 3 + grant_pct)
            op = FUNC_GRANT;
        else if (roll < 3 + grant_pct + (97 - grant_pct) / 2)
            op = FUNC_REVOKE;
        else
            op = FUNC_CHECK;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            kind = ns_kind;
        else if (roll < 70)
            kind = ep_kind;
        else if (roll < 75)
            kind = '0;
        else
            kind = KIND_W'($urandom_range(0, 15));
        res = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 75 && live_count > 0)
            h = cap_tbl[$urandom_range(0, live_count - 1)].handle;
        else if (roll < 88)
            h = HANDLE_W'($urandom_range(0, MAX_ENTRIES + 1));
        else
            h = HANDLE_W'($urandom_range(0, 255));
    endtask

    // result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                out_stall = idle_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result item with no item pending");
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.status));
                if (handle_out !== want.handle)
                    report_mismatch($sformatf("handle_out got %0d want %0d",
                                              handle_out, want.handle));
                if (send_allowed !== want.send)
                    report_mismatch($sformatf("send_allowed got %0d want %0d",
                                              send_allowed, want.send));
                if (endpoint_handle !== want.endpoint)
                    report_mismatch($sformatf("endpoint_handle got %0d want %0d",
                                              endpoint_handle, want.endpoint));
            end
        end
    end

    // stimulus
    initial
    begin
        logic [FUNC_W-1:0]   op;
        logic [KIND_W-1:0]   kind;
        logic [RES_W-1:0]    res;
        logic [HANDLE_W-1:0] h;
        int                  phase_ns [N_PHASES];
        int                  phase_ep [N_PHASES];

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_GRANT;
        cap_kind      = '0;
        resource_word = '0;
        handle_in     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_NAMESPACE_KIND;
        cfg_data      = '0;

        for (int i = 0; i < MAX_ENTRIES; i++)
            cap_tbl[i] = '0;
        live_count   = 0;
        cur_endpoint = '0;
        ns_kind      = NAMESPACE_KIND_RST;
        ep_kind      = ENDPOINT_KIND_RST;

        // edges of the table under the reset kind codes
        directed_rows = '{
            '{FUNC_CHECK,  4'd0,  64'd0, 8'd0,   1, 1'b1, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            '{FUNC_REVOKE, 4'd0,  64'd0, 8'd0,   1, 1'b1, '{ST_INVALID, 8'd0, 1'b0, 8'd0}},
            '{FUNC_REVOKE, 4'd0,  64'd0, 8'd5,   1, 1'b1, '{ST_INVALID, 8'd0, 1'b0, 8'd0}},
            '{FUNC_GRANT,  4'd0,  64'd0, 8'd0,   1, 1'b1, '{ST_LIMIT,   8'd0, 1'b0, 8'd0}},
            '{FUNC_UNUSED, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255,
              1, 1'b1, '{ST_INVALID, 8'd0, 1'b0, 8'd0}},
            '{FUNC_GRANT,  4'd1,  64'hFFFF_FFFF_FFFF_FFFF, 8'd0,
              1, 1'b1, '{ST_OK, 8'd1, 1'b0, 8'd0}},
            '{FUNC_GRANT,  4'd2,  64'd0, 8'd0,   1, 1'b1, '{ST_OK,      8'd2, 1'b0, 8'd2}},
            '{FUNC_GRANT,  4'd15, 64'hA5A5_A5A5_A5A5_A5A5, 8'd0,
              1, 1'b1, '{ST_OK, 8'd3, 1'b0, 8'd2}},
            '{FUNC_CHECK,  4'd0,  64'd0, 8'd1,   1, 1'b1, '{ST_OK,      8'd0, 1'b1, 8'd2}},
            '{FUNC_CHECK,  4'd0,  64'd0, 8'd3,   1, 1'b1, '{ST_OK,      8'd0, 1'b0, 8'd2}},
            '{FUNC_CHECK,  4'd0,  64'd0, 8'd255, 1, 1'b1, '{ST_OK,      8'd0, 1'b0, 8'd2}},
            '{FUNC_REVOKE, 4'd0,  64'd0, 8'd2,   1, 1'b1, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            // duplicate handle after compaction
            '{FUNC_GRANT,  4'd1,  64'h5555_5555_5555_5555, 8'd0,
              1, 1'b1, '{ST_OK, 8'd3, 1'b0, 8'd0}},
            '{FUNC_CHECK,  4'd0,  64'd0, 8'd3,   1, 1'b0, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            '{FUNC_REVOKE, 4'd0,  64'd0, 8'd3,   1, 1'b0, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            '{FUNC_CHECK,  4'd0,  64'd0, 8'd3,   1, 1'b0, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            // fill the table, then overflow it
            '{FUNC_GRANT,  4'd7,  64'h0123_4567_89AB_CDEF, 8'd0,
              MAX_ENTRIES - 2, 1'b0, '{ST_OK, 8'd0, 1'b0, 8'd0}},
            '{FUNC_GRANT,  4'd1,  64'd0, 8'd0,   1, 1'b1, '{ST_LIMIT,   8'd0, 1'b0, 8'd0}},
            '{FUNC_CHECK,  4'd0,  64'd0, 8'd16,  1, 1'b0, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            '{FUNC_REVOKE, 4'd0,  64'd0, 8'd255, 1, 1'b1, '{ST_INVALID, 8'd0, 1'b0, 8'd0}},
            '{FUNC_REVOKE, 4'd0,  64'd0, 8'd1,   1, 1'b0, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            '{FUNC_GRANT,  4'd2,  64'd0, 8'd0,   1, 1'b0, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            '{FUNC_REVOKE, 4'd0,  64'd0, 8'd16,  1, 1'b0, '{ST_OK,      8'd0, 1'b0, 8'd0}},
            '{FUNC_CHECK,  4'd0,  64'd0, 8'd0,   1, 1'b0, '{ST_OK,      8'd0, 1'b0, 8'd0}}
        };

        // kind-code settings per random phase, extremes first
        phase_ns = '{15, 1, 15, 4, 0};
        phase_ep = '{1, 15, 15, 4, 0};
        phase_ns[N_PHASES - 1] = $urandom_range(1, 15);
        phase_ep[N_PHASES - 1] = $urandom_range(1, 15);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                send_item(directed_rows[r].op, directed_rows[r].kind, directed_rows[r].res,
                          directed_rows[r].handle, directed_rows[r].typed,
                          directed_rows[r].want);

        // random phases
        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
            begin
                write_reg(REG_IDX_UNUSED, 4'd15);
                write_reg(REG_IDX_TOP, 4'd15);
            end
            write_reg(REG_NAMESPACE_KIND, KIND_W'(phase_ns[p]));
            write_reg(REG_ENDPOINT_KIND, KIND_W'(phase_ep[p]));
            idle_on = (p != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // receiver hold-off while items keep coming
                if (p == 1 && n == 100)
                    hold_request = 1'b1;
                // sender pause until the table has answered everything
                if (p == 3 && n == 150)
                    wait_drained();
                pick_random_item(op, kind, res, h);
                send_item(op, kind, res, h, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("expected result items never arrived");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/cptab_pkg.sv
rtl/core/cptab_mem.sv
rtl/core/cptab_cfg.sv
rtl/core/capability_table_core.sv
dv/capability_table_core_test.sv
